[rtl/settable_clock_with_debounce_defines.svh]
// Assertion macros for the settable clock. SCCD_ASSERT expects clk and arst_n in scope, SCCD_ASSERT_ALWAYS only clk.
`ifndef SETTABLE_CLOCK_WITH_DEBOUNCE_DEFINES_SVH
`define SETTABLE_CLOCK_WITH_DEBOUNCE_DEFINES_SVH
`ifndef SYNTH
// checked only out of reset
`define SCCD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("sccd assertion failed");
// checked at every edge, also during reset
`define SCCD_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("sccd assertion failed");
`else
`define SCCD_ASSERT(lbl, prop)
`define SCCD_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

[rtl/sccd_pkg.sv]
package sccd_pkg;

	localparam logic [4:0] HOUR_MAX   = 5'd23;
	localparam logic [5:0] MINSEC_MAX = 6'd59;
	localparam logic [4:0] HOUR_RST   = 5'd23;
	localparam logic [5:0] MINUTE_RST = 6'd59;
	localparam logic [5:0] SECOND_RST = 6'd45;

	localparam logic [15:0] TPS_RST  = 16'd100;
	localparam logic [7:0]  DEB_RST  = 8'd4;
	localparam logic [9:0]  HOLD_RST = 10'd50;
	localparam logic [7:0]  RPT_RST  = 8'd11;

	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	localparam logic [3:0] BTN_SEC  = 4'b0001;
	localparam logic [3:0] BTN_MIN  = 4'b0010;
	localparam logic [3:0] BTN_HOUR = 4'b0100;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TPS  = 2'd0,
		REG_DEB  = 2'd1,
		REG_HOLD = 2'd2,
		REG_RPT  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [4:0] hours;
		logic [5:0] minutes;
		logic [5:0] seconds;
	} time_t;

	typedef struct packed {
		logic [15:0] ticks_per_second;
		logic [7:0]  debounce_ticks;
		logic [9:0]  hold_ticks;
		logic [7:0]  repeat_ticks;
	} cfg_t;

	// time updates requested by the control logic for one beat
	typedef struct packed {
		logic       rpt_adj;
		logic       deb_adj;
		logic       advance;
		logic       up;
		logic [3:0] sel;
	} event_t;

	function automatic logic [5:0] wrap_step(logic [5:0] v, logic [5:0] maxv, logic up);
		logic [5:0] r;
		if (up)
			r = (v >= maxv) ? 6'd0 : v + 6'd1;
		else
			r = (v == 6'd0 || v > maxv) ? maxv : v - 6'd1;
		return r;
	endfunction

	function automatic time_t adjust(time_t t, logic [3:0] sel, logic up);
		time_t r;
		logic [5:0] h;
		r = t;
		h = wrap_step({1'b0, t.hours}, {1'b0, HOUR_MAX}, up);
		// values other than the seconds, minutes or hours button alone leave the time alone
		unique case (sel)
			BTN_SEC:  r.seconds = wrap_step(t.seconds, MINSEC_MAX, up);
			BTN_MIN:  r.minutes = wrap_step(t.minutes, MINSEC_MAX, up);
			BTN_HOUR: r.hours = h[4:0];
			default: ;
		endcase
		return r;
	endfunction

	function automatic time_t advance(time_t t);
		time_t r;
		logic [5:0] h;
		r = t;
		h = wrap_step({1'b0, t.hours}, {1'b0, HOUR_MAX}, 1'b1);
		r.seconds = wrap_step(t.seconds, MINSEC_MAX, 1'b1);
		if (r.seconds == 6'd0) begin
			r.minutes = wrap_step(t.minutes, MINSEC_MAX, 1'b1);
			if (r.minutes == 6'd0)
				r.hours = h[4:0];
		end
		return r;
	endfunction

endpackage

[rtl/sccd_item_if.sv]
interface sccd_item_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [3:0] buttons_now;
	logic       count_up;
	logic       pause;

	modport source (output valid, output action, output buttons_now, output count_up,
		output pause, input ready);
	modport sink (input valid, input action, input buttons_now, input count_up,
		input pause, output ready);
endinterface

[rtl/sccd_result_if.sv]
interface sccd_result_if;
	logic       valid;
	logic       ready;
	logic [4:0] hours;
	logic [5:0] minutes;
	logic [5:0] seconds;

	modport source (output valid, output hours, output minutes, output seconds, input ready);
	modport sink (input valid, input hours, input minutes, input seconds, output ready);
endinterface

[rtl/sccd_cfg.sv]
module sccd_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sccd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sccd_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output sccd_pkg::cfg_t                   cfg
);

	sccd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ticks_per_second <= sccd_pkg::TPS_RST;
			cfg_q.debounce_ticks   <= sccd_pkg::DEB_RST;
			cfg_q.hold_ticks       <= sccd_pkg::HOLD_RST;
			cfg_q.repeat_ticks     <= sccd_pkg::RPT_RST;
		end else if (cfg_we) begin
			unique case (sccd_pkg::cfg_reg_t'(cfg_index))
				sccd_pkg::REG_TPS:  cfg_q.ticks_per_second <= cfg_wdata;
				sccd_pkg::REG_DEB:  cfg_q.debounce_ticks   <= cfg_wdata[7:0];
				sccd_pkg::REG_HOLD: cfg_q.hold_ticks       <= cfg_wdata[9:0];
				sccd_pkg::REG_RPT:  cfg_q.repeat_ticks     <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/sccd_ctrl.sv]
module sccd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sccd_pkg::cfg_t       cfg,
	input  logic                 step,
	input  logic                 action,
	input  logic [3:0]           buttons_now,
	input  logic                 count_up,
	input  logic                 pause,
	output sccd_pkg::event_t     ev,
	output logic                 released
);

	logic [15:0] tick_q, tick_d, tick_inc;
	logic [7:0]  quiet_q, quiet_d;
	logic [9:0]  hold_q, hold_d;
	logic [7:0]  rpt_q, rpt_d, rpt_inc;
	logic        rpt_on_q, rpt_on_d;
	logic        released_q, released_d;
	logic [3:0]  latched_q, latched_d;
	logic [3:0]  prev_q, prev_d;
	logic        deb_hit, sec_hit;

	always_comb begin
		tick_d     = tick_q;
		quiet_d    = quiet_q;
		hold_d     = hold_q;
		rpt_d      = rpt_q;
		rpt_on_d   = rpt_on_q;
		released_d = released_q;
		latched_d  = latched_q;
		prev_d     = prev_q;
		deb_hit    = 1'b0;
		sec_hit    = 1'b0;
		tick_inc   = (tick_q != 16'hFFFF) ? tick_q + 16'd1 : tick_q;
		rpt_inc    = 8'd0;
		ev         = '0;
		ev.up      = count_up;
		ev.sel     = latched_q;

		if (action) begin
			latched_d = buttons_now;
			quiet_d   = 8'd0;
		end else begin
			if (quiet_q != 8'hFF) begin
				quiet_d = quiet_q + 8'd1;
				deb_hit = (quiet_d == cfg.debounce_ticks);
			end

			// hold timer
			if (!released_q)
				hold_d = (hold_q != 10'h3FF) ? hold_q + 10'd1 : hold_q;
			else begin
				hold_d   = 10'd0;
				rpt_on_d = 1'b0;
			end
			if (hold_d == cfg.hold_ticks)
				rpt_on_d = 1'b1;

			// auto repeat
			if (rpt_on_d) begin
				rpt_inc = (rpt_q != 8'hFF) ? rpt_q + 8'd1 : rpt_q;
				if (rpt_inc == cfg.repeat_ticks) begin
					rpt_d      = 8'd0;
					ev.rpt_adj = 1'b1;
				end else
					rpt_d = rpt_inc;
			end else
				rpt_d = 8'd0;

			// debounce acceptance
			if (deb_hit) begin
				if (latched_q != prev_q)
					released_d = !released_q;
				ev.deb_adj = 1'b1;
				prev_d     = latched_q;
			end

			sec_hit = (tick_inc >= cfg.ticks_per_second);
			tick_d  = sec_hit ? 16'd0 : tick_inc;
			ev.advance = sec_hit && !pause && released_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q     <= '0;
			quiet_q    <= '0;
			hold_q     <= '0;
			rpt_q      <= '0;
			rpt_on_q   <= 1'b0;
			released_q <= 1'b1;
			latched_q  <= '0;
			prev_q     <= '0;
		end else if (step) begin
			tick_q     <= tick_d;
			quiet_q    <= quiet_d;
			hold_q     <= hold_d;
			rpt_q      <= rpt_d;
			rpt_on_q   <= rpt_on_d;
			released_q <= released_d;
			latched_q  <= latched_d;
			prev_q     <= prev_d;
		end
	end

	assign released = released_q;

endmodule

[rtl/sccd_time.sv]
module sccd_time (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  sccd_pkg::event_t  ev,
	output sccd_pkg::time_t   cur_time,
	output sccd_pkg::time_t   next_time
);

	sccd_pkg::time_t time_q, t_rpt, t_deb;

	// repeat adjust, then debounce adjust, then the one-second advance
	always_comb begin
		t_rpt     = ev.rpt_adj ? sccd_pkg::adjust(time_q, ev.sel, ev.up) : time_q;
		t_deb     = ev.deb_adj ? sccd_pkg::adjust(t_rpt, ev.sel, ev.up) : t_rpt;
		next_time = ev.advance ? sccd_pkg::advance(t_deb) : t_deb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q.hours   <= sccd_pkg::HOUR_RST;
			time_q.minutes <= sccd_pkg::MINUTE_RST;
			time_q.seconds <= sccd_pkg::SECOND_RST;
		end else if (step) begin
			time_q <= next_time;
		end
	end

	assign cur_time = time_q;

endmodule

[rtl/settable_clock_with_debounce.sv]
// Channel   Dir  Payload                                  Beat when
// item      in   action, buttons_now, count_up, pause     item.valid && item.ready
// result    out  hours, minutes, seconds                  result.valid && result.ready
// cfg       in   cfg_index, cfg_wdata                     cfg_we
//
// One item per cycle sustained while result.ready holds; a stalled result holds items back.
// Latency is the input register plus the result register; the step logic between
// them is a few counter compares and one chain of three time adjusts.
// arst_n puts the time at 23:59:45 and the registers at their defaults.
// A stalled result holds the step stage; the input register still takes a beat
// while the step stage is empty or moving.

`include "settable_clock_with_debounce_defines.svh"

module settable_clock_with_debounce (
	input  logic                             clk,
	input  logic                             arst_n,
	sccd_item_if.sink                        item,
	sccd_result_if.source                    result,
	input  logic                             cfg_we,
	input  logic [sccd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sccd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	sccd_pkg::cfg_t   cfg;
	sccd_pkg::event_t ev;
	sccd_pkg::time_t  cur_time, next_time, res_time_q;

	// input register
	logic       valid_s1;
	logic       action_s1;
	logic [3:0] buttons_s1;
	logic       count_up_s1;
	logic       pause_s1;

	logic res_valid_q;
	logic step;
	logic in_beat;
	logic released;

	// step stage moves when it holds an item and the result register is free
	assign step    = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || step;
	assign in_beat = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_beat) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (in_beat) begin
			action_s1   <= item.action;
			buttons_s1  <= item.buttons_now;
			count_up_s1 <= item.count_up;
			pause_s1    <= item.pause;
		end
	end

	sccd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	sccd_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.step        (step),
		.action      (action_s1),
		.buttons_now (buttons_s1),
		.count_up    (count_up_s1),
		.pause       (pause_s1),
		.ev          (ev),
		.released    (released)
	);

	sccd_time u_time (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.ev        (ev),
		.cur_time  (cur_time),
		.next_time (next_time)
	);

	// result register: the time after the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_time_q <= next_time;
		end
	end

	assign result.valid   = res_valid_q;
	assign result.hours   = res_time_q.hours;
	assign result.minutes = res_time_q.minutes;
	assign result.seconds = res_time_q.seconds;

	// time never leaves its legal range, reset included
	`SCCD_ASSERT_ALWAYS(a_time_range, (cur_time.hours <= sccd_pkg::HOUR_MAX && cur_time.minutes <= sccd_pkg::MINSEC_MAX && cur_time.seconds <= sccd_pkg::MINSEC_MAX))
	// a button beat leaves the time as it was
	`SCCD_ASSERT(a_button_keeps_time, (step && action_s1) |=> $stable(cur_time))
	// the pressed flag moves only on a tick that went through the step stage
	`SCCD_ASSERT(a_release_on_tick, !$stable(released) |-> $past(step && !action_s1))
	// the result just loaded matches the time registers
	`SCCD_ASSERT(a_result_tracks_time, $past(step) |-> (res_time_q == cur_time))

endmodule
